[rtl/sh24_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash-2-4 package
// Shared widths, initialisation constants, codes and helper functions.
// ----------------------------------------------------------------------------
package sh24_pkg;

  localparam int WordW   = 64;
  localparam int ByteW   = 8;
  localparam int CfgIdxW = 2;

  localparam logic [WordW-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [WordW-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [WordW-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [WordW-1:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [WordW-1:0] SIP_FIN_XOR = 64'h00000000000000ff;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd1;

  // Item actions.
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // The four mixing words.
  typedef struct packed {
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] v2;
    logic [WordW-1:0] v3;
  } sip_state_t;

  // Rotate left by a constant amount.
  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] x, input int n);
    rotl64 = (x << n) | (x >> (WordW - n));
  endfunction

  // Starting state derived from the key.
  function automatic sip_state_t sip_init(input logic [WordW-1:0] k0,
                                          input logic [WordW-1:0] k1);
    sip_state_t s;
    s.v0 = SIP_C0 ^ k0;
    s.v1 = SIP_C1 ^ k1;
    s.v2 = SIP_C2 ^ k0;
    s.v3 = SIP_C3 ^ k1;
    sip_init = s;
  endfunction

endpackage

[rtl/sh24_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash input channel
// Valid/ready channel carrying one absorb or finish item.
// ----------------------------------------------------------------------------
interface sh24_in_if
  import sh24_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

[rtl/sh24_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash result channel
// Valid/ready channel carrying one 64-bit hash item.
// ----------------------------------------------------------------------------
interface sh24_out_if
  import sh24_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

[rtl/siphash_2_4_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SipHash-2-4 stream hasher
// Keyed SipHash-2-4 over a byte stream, with one shared half-round unit.
// ----------------------------------------------------------------------------
// Usage:
//   The key is written through the cfg_ port (index 0 key low, index 1 key
//   high) while the block is idle; each write restarts the current message.
//   Items on in_ch either absorb one message byte or finish the message.
//   An absorb item is packed into the pending word, except every eighth byte,
//   which completes the word and then runs four half-rounds (two SipRounds).
//   A finish item runs, after the accept, four half-rounds for the last
//   block, eight half-rounds for the four final rounds and then the output
//   step that forms the hash, which then appears on out_ch.
//   The rate is set by the single half-round unit: one half SipRound (two
//   64-bit adds with their rotates) per cycle. in_ch.ready is high only while
//   the sequencer is idle and no key write is under way.
//   The hash sits in an output register; if the receiver stalls, further
//   absorb items are still taken, and a later finish waits until the held
//   hash has been taken. Reset clears the key to zero and starts an empty
//   message; no hash is pending after reset.
// ----------------------------------------------------------------------------
module siphash_2_4_stream_hasher
  import sh24_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  sh24_in_if.sink            in_ch,
  sh24_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_data
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MIX  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [2:0] MixLastHalf = 3'd3;
  localparam logic [2:0] FinLastHalf = 3'd7;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       half_r, half_nxt;
  logic             fin_r, fin_nxt;
  logic [WordW-1:0] key_low_r, key_low_nxt;
  logic [WordW-1:0] key_high_r, key_high_nxt;
  sip_state_t       v_r, v_nxt;
  logic [WordW-1:0] pend_r, pend_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;
  logic [WordW-1:0] msg_r, msg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_hash_r, out_hash_nxt;

  logic             in_acc;
  logic             out_free;
  logic [2:0]       lane;
  logic [WordW-1:0] word_full;
  logic [WordW-1:0] last_block;
  sip_state_t       rnd;

  // Shared half-round unit: even steps run the first half of a SipRound,
  // odd steps the second half. The two adders are shared between halves.
  logic             phase_b;
  logic [WordW-1:0] sum_a, sum_c;
  logic [WordW-1:0] add_a_op, add_c_op;

  assign phase_b  = half_r[0];
  assign add_a_op = phase_b ? v_r.v3 : v_r.v1;
  assign add_c_op = phase_b ? v_r.v1 : v_r.v3;
  assign sum_a    = v_r.v0 + add_a_op;
  assign sum_c    = v_r.v2 + add_c_op;

  always_comb begin
    if (!phase_b) begin
      rnd.v0 = rotl64(sum_a, 32);
      rnd.v1 = rotl64(v_r.v1, 13) ^ sum_a;
      rnd.v2 = sum_c;
      rnd.v3 = rotl64(v_r.v3, 16) ^ sum_c;
    end else begin
      rnd.v0 = sum_a;
      rnd.v1 = rotl64(v_r.v1, 17) ^ sum_c;
      rnd.v2 = rotl64(sum_c, 32);
      rnd.v3 = rotl64(v_r.v3, 21) ^ sum_a;
    end
  end

  // Handshake and byte packing.
  assign in_ch.ready       = (state_r == S_IDLE) && !cfg_wr_en;
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  assign lane = cnt_r[2:0];

  always_comb begin
    word_full = pend_r;
    word_full[lane*ByteW +: ByteW] = in_ch.data_byte;
  end

  assign last_block = pend_r | {cnt_r, {(WordW-ByteW){1'b0}}};

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt     = state_r;
    half_nxt      = half_r;
    fin_nxt       = fin_r;
    key_low_nxt   = key_low_r;
    key_high_nxt  = key_high_r;
    v_nxt         = v_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    msg_nxt       = msg_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_wr_en && (cfg_index == CFG_KEY_LOW || cfg_index == CFG_KEY_HIGH)) begin
          // A key write restarts the message from the new key.
          if (cfg_index == CFG_KEY_LOW) begin
            key_low_nxt = cfg_data;
          end else begin
            key_high_nxt = cfg_data;
          end
          v_nxt    = sip_init(key_low_nxt, key_high_nxt);
          pend_nxt = '0;
          cnt_nxt  = '0;
        end else if (in_acc) begin
          half_nxt = '0;
          if (in_ch.action == ACT_ABSORB) begin
            cnt_nxt = cnt_r + 8'd1;
            if (lane == 3'd7) begin
              // Word complete: fold it into v3 and run two rounds.
              msg_nxt   = word_full;
              v_nxt.v3  = v_r.v3 ^ word_full;
              pend_nxt  = '0;
              fin_nxt   = 1'b0;
              state_nxt = S_MIX;
            end else begin
              pend_nxt = word_full;
            end
          end else begin
            // Final block carries the length byte in its top lane.
            msg_nxt   = last_block;
            v_nxt.v3  = v_r.v3 ^ last_block;
            fin_nxt   = 1'b1;
            state_nxt = S_MIX;
          end
        end
      end

      S_MIX: begin
        v_nxt    = rnd;
        half_nxt = half_r + 3'd1;
        if (half_r == MixLastHalf) begin
          v_nxt.v0 = rnd.v0 ^ msg_r;
          half_nxt = '0;
          if (fin_r) begin
            v_nxt.v2  = rnd.v2 ^ SIP_FIN_XOR;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_FIN: begin
        v_nxt    = rnd;
        half_nxt = half_r + 3'd1;
        if (half_r == FinLastHalf) begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        // Wait for the output register, then restart the message.
        if (out_free) begin
          out_hash_nxt  = v_r.v0 ^ v_r.v1 ^ v_r.v2 ^ v_r.v3;
          out_valid_nxt = 1'b1;
          v_nxt         = sip_init(key_low_r, key_high_r);
          pend_nxt      = '0;
          cnt_nxt       = '0;
          fin_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      half_r      <= '0;
      fin_r       <= 1'b0;
      key_low_r   <= '0;
      key_high_r  <= '0;
      v_r         <= sip_init('0, '0);
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      half_r      <= half_nxt;
      fin_r       <= fin_nxt;
      key_low_r   <= key_low_nxt;
      key_high_r  <= key_high_nxt;
      v_r         <= v_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    msg_r      <= msg_nxt;
    out_hash_r <= out_hash_nxt;
  end

  // Checks on the sequencer.
  a_mix_half_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX) |-> (half_r <= MixLastHalf))
    else $error("mix step count out of range");

  a_finish_enters_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.action == ACT_FINISH && !cfg_wr_en) |=> (state_r == S_MIX && fin_r))
    else $error("finish item did not start the final block");

  a_hash_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("hash presented outside the output step");

  a_top_lane_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pend_r[WordW-1 -: ByteW] == '0))
    else $error("pending word top lane not clear while idle");

endmodule
